// ----- rtl/lec_pkg.sv -----
package lec_pkg;

    localparam int SW  = 16;
    localparam int NCH = 3;

    localparam logic [SW-1:0] FS       = '1;
    localparam logic [33:0]   HALF34   = 34'(FS >> 1);

    // ratio divider: 16 quotient bits, 4 per stage
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = SW / DIV_STAGES;

    typedef enum logic [1:0] {
        MODE_UNION      = 2'd0,
        MODE_CLIP_BACK  = 2'd1,
        MODE_CLIP_LAYER = 2'd2,
        MODE_INTERSECT  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_MODE    = 2'd0,
        CFG_OPACITY = 2'd1,
        CFG_MASK_EN = 2'd2,
        CFG_NONE    = 2'd3
    } t_cfg_idx;

    // colour and sideband that ride along the pipeline
    typedef struct packed {
        logic [NCH-1:0][SW-1:0] back;
        logic [NCH-1:0][SW-1:0] lay;
        logic                   last;
    } t_pix;

    // floor(x / 65535) by folding the high part back in, one final correction
    function automatic logic [17:0] div_fs(input logic [33:0] x);
        logic [17:0] q0;
        logic [18:0] r;
        logic [16:0] r2;
        q0 = x[33:16];
        r  = 19'(x[15:0]) + 19'(q0);
        r2 = 17'(r[15:0]) + 17'(r[18:16]);
        return q0 + 18'(r[18:16]) + 18'((r2 >= 17'(FS)) ? 1 : 0);
    endfunction

endpackage

// ----- rtl/lec_alpha.sv -----
module lec_alpha
    import lec_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_rdy,
    input  t_pix          i_pix,
    input  logic [SW-1:0] i_back_alpha,
    input  logic [SW-1:0] i_alpha_in,
    input  logic [SW-1:0] i_mask,
    input  logic [SW-1:0] i_opacity,
    input  logic          i_mask_en,
    input  t_mode         i_mode,
    output logic          o_valid,
    input  logic          i_rdy,
    output t_pix          o_pix,
    output logic [SW-1:0] o_na,
    output logic [31:0]   o_p2
);

    localparam int NS = 6;

    logic [NS-1:0] r_v;
    logic [NS-1:0] rdy;

    t_pix          r1_pix, r2_pix, r3_pix, r4_pix, r5_pix, r6_pix;
    logic [SW-1:0] r1_ba, r2_ba, r3_ba, r4_ba;
    logic [SW-1:0] r1_mask, r2_mask;
    logic [31:0]   r1_prod, r3_prod;
    logic [SW-1:0] r2_la, r3_la, r4_la;
    logic [31:0]   r5_p1, r5_p2, r6_p2;
    logic [SW-1:0] r6_na;

    logic [SW-1:0] n2_la, n4_la, n6_na;
    logic [17:0]   q_la1, q_la2, q_un, q_cb, q_cl;

    always_comb begin
        rdy[NS-1] = !r_v[NS-1] || i_rdy;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_rdy = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    always_comb begin
        q_la1 = div_fs(34'(r1_prod) + HALF34);
        n2_la = q_la1[SW-1:0];
        q_la2 = div_fs(34'(r3_prod) + HALF34);
        n4_la = i_mask_en ? q_la2[SW-1:0] : r3_la;
        q_un  = div_fs(34'(r5_p1) + 34'(r5_p2) + HALF34);
        q_cb  = div_fs(34'(r5_p1) + HALF34);
        q_cl  = div_fs(34'(r5_p2) + HALF34);
        case (i_mode)
            MODE_UNION:      n6_na = q_un[SW-1:0];
            MODE_CLIP_BACK:  n6_na = q_cb[SW-1:0];
            MODE_CLIP_LAYER: n6_na = q_cl[SW-1:0];
            default:         n6_na = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r1_pix  <= i_pix;
            r1_ba   <= i_back_alpha;
            r1_mask <= i_mask;
            r1_prod <= i_alpha_in * i_opacity;
        end
        if (rdy[1] && r_v[0]) begin
            r2_pix  <= r1_pix;
            r2_ba   <= r1_ba;
            r2_mask <= r1_mask;
            r2_la   <= n2_la;
        end
        if (rdy[2] && r_v[1]) begin
            r3_pix  <= r2_pix;
            r3_ba   <= r2_ba;
            r3_la   <= r2_la;
            r3_prod <= r2_la * r2_mask;
        end
        if (rdy[3] && r_v[2]) begin
            r4_pix <= r3_pix;
            r4_ba  <= r3_ba;
            r4_la  <= n4_la;
        end
        if (rdy[4] && r_v[3]) begin
            r5_pix <= r4_pix;
            r5_p1  <= r4_ba * (FS - r4_la);
            r5_p2  <= r4_la * (FS - r4_ba);
        end
        if (rdy[5] && r_v[4]) begin
            r6_pix <= r5_pix;
            r6_na  <= n6_na;
            r6_p2  <= r5_p2;
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_pix   = r6_pix;
    assign o_na    = r6_na;
    assign o_p2    = r6_p2;

endmodule

// ----- rtl/lec_div.sv -----
module lec_div
    import lec_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_rdy,
    input  t_pix          i_pix,
    input  logic [SW-1:0] i_na,
    input  logic [31:0]   i_p2,
    output logic          o_valid,
    input  logic          i_rdy,
    output t_pix          o_pix,
    output logic [SW-1:0] o_na,
    output logic [SW-1:0] o_ratio
);

    localparam int NS = DIV_STAGES;

    logic [NS-1:0]         r_v;
    logic [NS-1:0]         rdy;
    t_pix                  r_pix  [NS];
    logic [NS-1:0][SW-1:0] r_na;
    logic [NS-1:0][SW-1:0] r_rem;
    logic [NS-1:0][SW-1:0] r_lo;
    logic [NS-1:0][SW-1:0] r_q;
    logic [NS-1:0]         r_sat;

    logic [NS-1:0][SW-1:0] n_rem;
    logic [NS-1:0][SW-1:0] n_lo;
    logic [NS-1:0][SW-1:0] n_q;
    logic [31:0]           num;
    logic                  sat_in;
    logic [SW:0]           t;

    always_comb begin
        rdy[NS-1] = !r_v[NS-1] || i_rdy;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_rdy = rdy[0];

    // numerator carries half the divisor for rounding; top half below na means q fits
    assign num    = i_p2 + 32'(i_na >> 1);
    assign sat_in = (num >= {i_na, 16'h0000});

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            n_rem[k] = (k == 0) ? num[31:16] : r_rem[k-1];
            n_lo[k]  = (k == 0) ? num[15:0]  : r_lo[k-1];
            n_q[k]   = (k == 0) ? '0         : r_q[k-1];
            for (int s = 0; s < DIV_STEPS; s++) begin
                t = {n_rem[k], n_lo[k][SW-1]};
                n_lo[k] = n_lo[k] << 1;
                if (t >= {1'b0, ((k == 0) ? i_na : r_na[k-1])}) begin
                    t = t - {1'b0, ((k == 0) ? i_na : r_na[k-1])};
                    n_q[k] = {n_q[k][SW-2:0], 1'b1};
                end else begin
                    n_q[k] = {n_q[k][SW-2:0], 1'b0};
                end
                n_rem[k] = t[SW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (rdy[k] && ((k == 0) ? i_valid : r_v[k-1])) begin
                r_pix[k] <= (k == 0) ? i_pix  : r_pix[k-1];
                r_na[k]  <= (k == 0) ? i_na   : r_na[k-1];
                r_sat[k] <= (k == 0) ? sat_in : r_sat[k-1];
                r_rem[k] <= n_rem[k];
                r_lo[k]  <= n_lo[k];
                r_q[k]   <= n_q[k];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_pix   = r_pix[NS-1];
    assign o_na    = r_na[NS-1];
    assign o_ratio = r_sat[NS-1] ? FS : r_q[NS-1];

endmodule

// ----- rtl/lec_blend.sv -----
module lec_blend
    import lec_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_rdy,
    input  t_pix                   i_pix,
    input  logic [SW-1:0]          i_na,
    input  logic [SW-1:0]          i_ratio,
    input  t_mode                  i_mode,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [NCH-1:0][SW-1:0] o_col,
    output logic [SW-1:0]          o_alpha,
    output logic                   o_last
);

    logic [1:0] r_v;
    logic [1:0] rdy;

    t_pix                   r1_pix;
    logic [SW-1:0]          r1_na;
    logic [NCH-1:0][31:0]   r1_pl;
    logic [NCH-1:0][31:0]   r1_pb;
    logic [NCH-1:0][SW-1:0] r2_col;
    logic [SW-1:0]          r2_alpha;
    logic                   r2_last;

    logic [NCH-1:0][SW-1:0] n2_col;
    logic [17:0]            q;

    assign rdy[1] = !r_v[1] || !i_stall;
    assign rdy[0] = !r_v[0] || rdy[1];
    assign o_rdy  = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            if (rdy[1]) begin
                r_v[1] <= r_v[0];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            q = div_fs(34'(r1_pl[c]) + 34'(r1_pb[c]) + HALF34);
            if (r1_na == '0) begin
                n2_col[c] = r1_pix.back[c];
            end else begin
                case (i_mode)
                    MODE_UNION:      n2_col[c] = q[SW-1:0];
                    MODE_CLIP_LAYER: n2_col[c] = r1_pix.lay[c];
                    default:         n2_col[c] = r1_pix.back[c];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r1_pix <= i_pix;
            r1_na  <= i_na;
            for (int c = 0; c < NCH; c++) begin
                r1_pl[c] <= i_ratio * i_pix.lay[c];
                r1_pb[c] <= (FS - i_ratio) * i_pix.back[c];
            end
        end
        if (rdy[1] && r_v[0]) begin
            r2_col   <= n2_col;
            r2_alpha <= r1_na;
            r2_last  <= r1_pix.last;
        end
    end

    assign o_valid = r_v[1];
    assign o_col   = r2_col;
    assign o_alpha = r2_alpha;
    assign o_last  = r2_last;

endmodule

// ----- rtl/layer_erase_composite.sv -----
// Erase-mode layer compositing, one pixel per transaction.
// Input channel: i_valid / o_stall with backdrop colour and alpha, layer colour
// and alpha, mask weight and last flag. Output channel: o_valid / i_stall with
// the erased colour, alpha and the copied last flag.
// Configuration: i_cfg_we writes i_cfg_idx (0 mode, 1 opacity, 2 mask enable)
// on the clock edge; change it only while the pipeline is empty.
// The path from input transaction to the output register has six stages for
// effective alpha and new alpha (multiplies and rounded divides by full
// scale in alternate stages), four stages of the union ratio divider at
// four quotient bits each, two blend stages. Throughput is one pixel
// per clock while the output is not stalled; every stage has its own
// valid bit. A stall on the output fills bubbles first, so input is
// taken until the whole pipeline is full; nothing is dropped or repeated.
// Synchronous reset empties the pipeline and sets mode to clip to backdrop,
// opacity to full and masking off.
module layer_erase_composite
    import lec_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [15:0]   i_back_c0,
    input  logic [15:0]   i_back_c1,
    input  logic [15:0]   i_back_c2,
    input  logic [15:0]   i_back_alpha,
    input  logic [15:0]   i_layer_c0,
    input  logic [15:0]   i_layer_c1,
    input  logic [15:0]   i_layer_c2,
    input  logic [15:0]   i_layer_alpha_in,
    input  logic [15:0]   i_mask_value,
    input  logic          i_last_pixel,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [15:0]   o_out_c0,
    output logic [15:0]   o_out_c1,
    output logic [15:0]   o_out_c2,
    output logic [15:0]   o_out_alpha,
    output logic          o_out_last
);

    t_mode         r_mode;
    logic [SW-1:0] r_opacity;
    logic          r_mask_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_CLIP_BACK;
            r_opacity <= FS;
            r_mask_en <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:    r_mode    <= t_mode'(i_cfg_data[1:0]);
                CFG_OPACITY: r_opacity <= i_cfg_data;
                CFG_MASK_EN: r_mask_en <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    t_pix                   in_pix, a_pix, d_pix;
    logic                   a_rdy, a_valid, d_rdy, d_valid, b_rdy;
    logic [SW-1:0]          a_na, d_na, d_ratio;
    logic [31:0]            a_p2;
    logic [NCH-1:0][SW-1:0] col;

    assign in_pix.back = {i_back_c2, i_back_c1, i_back_c0};
    assign in_pix.lay  = {i_layer_c2, i_layer_c1, i_layer_c0};
    assign in_pix.last = i_last_pixel;

    lec_alpha u_alpha (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_rdy        (a_rdy),
        .i_pix        (in_pix),
        .i_back_alpha (i_back_alpha),
        .i_alpha_in   (i_layer_alpha_in),
        .i_mask       (i_mask_value),
        .i_opacity    (r_opacity),
        .i_mask_en    (r_mask_en),
        .i_mode       (r_mode),
        .o_valid      (a_valid),
        .i_rdy        (d_rdy),
        .o_pix        (a_pix),
        .o_na         (a_na),
        .o_p2         (a_p2)
    );

    lec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (a_valid),
        .o_rdy   (d_rdy),
        .i_pix   (a_pix),
        .i_na    (a_na),
        .i_p2    (a_p2),
        .o_valid (d_valid),
        .i_rdy   (b_rdy),
        .o_pix   (d_pix),
        .o_na    (d_na),
        .o_ratio (d_ratio)
    );

    lec_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .o_rdy   (b_rdy),
        .i_pix   (d_pix),
        .i_na    (d_na),
        .i_ratio (d_ratio),
        .i_mode  (r_mode),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_col   (col),
        .o_alpha (o_out_alpha),
        .o_last  (o_out_last)
    );

    assign o_stall  = !a_rdy;
    assign o_out_c0 = col[0];
    assign o_out_c1 = col[1];
    assign o_out_c2 = col[2];

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import lec_pkg::*;

    localparam logic [63:0] FULL = 64'd65535;
    localparam logic [63:0] HALF = 64'd32767;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] c0, c1, c2, alpha;
        logic        last;
    } t_erased;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_NONE;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_back_c0 = '0, i_back_c1 = '0, i_back_c2 = '0, i_back_alpha = '0;
    logic [15:0] i_layer_c0 = '0, i_layer_c1 = '0, i_layer_c2 = '0;
    logic [15:0] i_layer_alpha_in = '0, i_mask_value = '0;
    logic        i_last_pixel = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_out_c0, o_out_c1, o_out_c2, o_out_alpha;
    logic        o_out_last;

    layer_erase_composite i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor's copy of the registers
    t_mode       cur_mode = MODE_CLIP_BACK;
    logic [15:0] cur_opacity = 16'hFFFF;
    logic        cur_mask_en = 1'b0;

    t_erased pixel_queue[$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      hold_off = 1'b0;
    int      idle_cycles = 0;

    function automatic logic [63:0] rnd_mul(logic [63:0] a, logic [63:0] b);
        return (a * b + HALF) / FULL;
    endfunction

    function automatic t_erased erase_pixel(logic [15:0] bk[3], logic [15:0] ly[3],
                                            logic [15:0] ba16, logic [15:0] la16,
                                            logic [15:0] mk, logic last);
        t_erased     res;
        logic [63:0] ba, la, na, r;
        logic [63:0] col[3];
        ba = ba16;
        la = rnd_mul(la16, cur_opacity);
        if (cur_mask_en) la = rnd_mul(la, mk);
        for (int k = 0; k < 3; k++) col[k] = bk[k];
        case (cur_mode)
            MODE_UNION: begin
                na = (ba * (FULL - la) + la * (FULL - ba) + HALF) / FULL;
                if (na != 0) begin
                    r = ((FULL - ba) * la + (na >> 1)) / na;
                    if (r > FULL) r = FULL;
                    for (int k = 0; k < 3; k++)
                        col[k] = (r * ly[k] + (FULL - r) * bk[k] + HALF) / FULL;
                end
            end
            MODE_CLIP_BACK: na = rnd_mul(FULL - la, ba);
            MODE_CLIP_LAYER: begin
                na = rnd_mul(FULL - ba, la);
                if (na != 0)
                    for (int k = 0; k < 3; k++) col[k] = ly[k];
            end
            default: na = 0;
        endcase
        res.c0 = col[0][15:0];
        res.c1 = col[1][15:0];
        res.c2 = col[2][15:0];
        res.alpha = na[15:0];
        res.last = last;
        return res;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_NONE;
        case (idx)
            CFG_MODE:    cur_mode = t_mode'(val[1:0]);
            CFG_OPACITY: cur_opacity = val;
            CFG_MASK_EN: cur_mask_en = val[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic configure(t_mode m, logic [15:0] op, logic me);
        drain();
        write_reg(CFG_MODE, 16'(m));
        write_reg(CFG_OPACITY, op);
        write_reg(CFG_MASK_EN, 16'(me));
    endtask

    // drives one transaction and holds it until accepted; valid drops only when idling
    task automatic send_pixel(logic [15:0] bk[3], logic [15:0] ly[3], logic [15:0] ba,
                              logic [15:0] la, logic [15:0] mk, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_back_c0 <= bk[0]; i_back_c1 <= bk[1]; i_back_c2 <= bk[2];
        i_layer_c0 <= ly[0]; i_layer_c1 <= ly[1]; i_layer_c2 <= ly[2];
        i_back_alpha <= ba;
        i_layer_alpha_in <= la;
        i_mask_value <= mk;
        i_last_pixel <= last;
        pixel_queue.push_back(erase_pixel(bk, ly, ba, la, mk, last));
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic logic [15:0] edge_val();
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(1 << $urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(bit extremes);
        logic [15:0] bk[3], ly[3];
        for (int k = 0; k < 3; k++) begin
            bk[k] = extremes ? edge_val() : 16'($urandom);
            ly[k] = extremes ? edge_val() : 16'($urandom);
        end
        send_pixel(bk, ly, extremes ? edge_val() : 16'($urandom),
                   extremes ? edge_val() : 16'($urandom),
                   extremes ? edge_val() : 16'($urandom), 1'($urandom));
    endtask

    task automatic test_directed();
        logic [15:0] zero3[3] = '{16'h0, 16'h0, 16'h0};
        logic [15:0] full3[3] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        logic [15:0] mix3[3] = '{16'h1234, 16'h8000, 16'hFFFF};
        for (int m = 0; m < 4; m++) begin
            configure(t_mode'(m), 16'hFFFF, 1'b1);
            send_pixel(zero3, full3, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
            send_pixel(full3, zero3, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b0);
            send_pixel(mix3, full3, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
            // small and large alpha pairs with full, zero and minimal mask, in every mode
            send_pixel(mix3, zero3, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b0);
            send_pixel(full3, mix3, 16'h0001, 16'h0001, 16'h0000, 1'b1);
            send_pixel(mix3, mix3, 16'h8000, 16'h7FFF, 16'h0001, 1'b0);
        end
    endtask

    task automatic test_random_phase(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0)
                configure(t_mode'($urandom_range(3)),
                          ($urandom_range(3) == 0) ? 16'hFFFF :
                          ($urandom_range(5) == 0) ? 16'h0000 : 16'($urandom),
                          1'($urandom));
            send_random($urandom_range(4) == 0);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int n = 0; n < 40; n++) send_random(1'b0);
        drain();
    endtask

    // long stall in its own process so the pipeline fills up
    always @(posedge i_clk) begin
        if (hold_off) begin
            i_stall <= 1'b1;
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 200) hold_off <= 1'b0;
        end else begin
            idle_cycles <= 0;
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_erased want, got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_out_c0, o_out_c1, o_out_c2, o_out_alpha, o_out_last};
            if (pixel_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected result exp none got %h", $time, got);
            end else begin
                want = pixel_queue.pop_front();
                if (got.c0 !== want.c0)
                    $display("%0t: c0 exp %h got %h", $time, want.c0, got.c0);
                if (got.c1 !== want.c1)
                    $display("%0t: c1 exp %h got %h", $time, want.c1, got.c1);
                if (got.c2 !== want.c2)
                    $display("%0t: c2 exp %h got %h", $time, want.c2, got.c2);
                if (got.alpha !== want.alpha)
                    $display("%0t: alpha exp %h got %h", $time, want.alpha, got.alpha);
                if (got.last !== want.last)
                    $display("%0t: last exp %b got %b", $time, want.last, got.last);
                if (got !== want) errors++;
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // reset defaults first
        send_random(1'b0);
        send_random(1'b1);
        test_directed();
        send_idle_pct = 22; recv_idle_pct = 45;
        test_random_phase(340);
        test_backpressure();
        send_idle_pct = 45; recv_idle_pct = 22;
        test_random_phase(340);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random_phase(340);
        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/lec_pkg.sv
rtl/lec_alpha.sv
rtl/lec_div.sv
rtl/lec_blend.sv
rtl/layer_erase_composite.sv
test/tb.sv
